>>> rtl/core/cylindrical_uv_mapper_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef CYLINDRICAL_UV_MAPPER_DEFINES_SVH
`define CYLINDRICAL_UV_MAPPER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CUV_ASSERT_IMP(label, clk_s, rst_ns, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
        else $error("cuv implication failed");

// Check that a condition implies a consequence in the next cycle.
`define CUV_ASSERT_NEXT(label, clk_s, rst_ns, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
        else $error("cuv next-cycle check failed");

`endif

>>> rtl/core/cuv_pkg.sv
package cuv_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int COORD_BITS   = 16;
    localparam int ATAN_ENTRIES = 24;

    // Transformed coordinate: 3 products of 32 bits plus translation, 20 fraction bits
    localparam int TW = 35;
    // CORDIC datapath width: COORD_BITS plus growth and sign
    localparam int CW = COORD_BITS + 3;
    // Angle accumulator in 2^-32 turn
    localparam int AW = 34;
    // Number of stages ahead of the CORDIC chain, and after it
    localparam int PRE_STAGES  = 4;
    localparam int POST_STAGES = 3;
    localparam int DEPTH       = PRE_STAGES + CORDIC_STEPS + POST_STAGES;

    localparam logic [2:0] REG_ROW_X = 3'd0;
    localparam logic [2:0] REG_ROW_Y = 3'd1;
    localparam logic [2:0] REG_ROW_Z = 3'd2;
    localparam logic [2:0] REG_TILE_U = 3'd3;
    localparam logic [2:0] REG_TILE_V = 3'd4;
    localparam logic [2:0] REG_WRAP  = 3'd5;

    localparam logic [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [AW-1:0] acc;
        logic signed [31:0]   v;
    } cell_word_t;

    function automatic logic signed [AW-1:0] atan_turn(input int idx);
        logic signed [AW-1:0] r;
        begin
            unique case (idx)
                0: r = AW'(64'sd536870912);
                1: r = AW'(64'sd316933406);
                2: r = AW'(64'sd167458907);
                3: r = AW'(64'sd85004756);
                4: r = AW'(64'sd42667331);
                5: r = AW'(64'sd21354465);
                6: r = AW'(64'sd10679838);
                7: r = AW'(64'sd5340245);
                8: r = AW'(64'sd2670163);
                9: r = AW'(64'sd1335087);
                10: r = AW'(64'sd667544);
                11: r = AW'(64'sd333772);
                12: r = AW'(64'sd166886);
                13: r = AW'(64'sd83443);
                14: r = AW'(64'sd41722);
                15: r = AW'(64'sd20861);
                16: r = AW'(64'sd10430);
                17: r = AW'(64'sd5215);
                18: r = AW'(64'sd2608);
                19: r = AW'(64'sd1304);
                20: r = AW'(64'sd652);
                21: r = AW'(64'sd326);
                22: r = AW'(64'sd163);
                23: r = AW'(64'sd81);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/core/cuv_cordic_cell.sv
// One vectoring CORDIC iteration with a register after it.
module cuv_cordic_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [4:0]                 shift,
    input  logic signed [cuv_pkg::AW-1:0] angle,
    input  cuv_pkg::cell_word_t        din,
    output cuv_pkg::cell_word_t        dout
);
    cuv_pkg::cell_word_t word_next;
    cuv_pkg::cell_word_t word_reg;
    logic signed [cuv_pkg::CW-1:0] dx;
    logic signed [cuv_pkg::CW-1:0] dy;

    // Rotate toward the x axis by the step angle
    always_comb
    begin
        dx = din.cy >>> shift;
        dy = din.cx >>> shift;
        word_next = din;
        if (!din.cy[cuv_pkg::CW-1])
        begin
            word_next.cx  = din.cx + dx;
            word_next.cy  = din.cy - dy;
            word_next.acc = din.acc + angle;
        end
        else
        begin
            word_next.cx  = din.cx - dx;
            word_next.cy  = din.cy + dy;
            word_next.acc = din.acc - angle;
        end
    end

    // Advance when the chain moves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;
endmodule

>>> rtl/core/cylindrical_uv_mapper.sv
// Cylindrical UV mapper.
// in channel: pos_x/pos_y/pos_z (Q8.8) under in_valid/in_ready.
// out channel: tex_u (Q15.16) / tex_v (Q16.15), saturated, under out_valid/out_ready.
// cfg channel: cfg_index/cfg_data under cfg_valid/cfg_ready, always ready;
//   write only while the block is idle. Unknown indexes are dropped.
// Throughput: one vertex per cycle while out_ready stays high. From the
//   accepting edge to out_valid a vertex passes 23 registers: 4
//   transform/normalize stages, 16 CORDIC cells, 3 output stages.
// Each slot advances when the slot ahead advances or is empty; when the
//   receiver stalls with a word waiting at the output, full slots hold
//   but empty slots still fill, so in_ready stays high and the block keeps
//   taking words until the chain is full.
// Reset clears all valid bits and loads the identity transform, unit tiles
//   and wrap on.
module cylindrical_uv_mapper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] tex_u,
    output logic signed [31:0] tex_v,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
`include "cylindrical_uv_mapper_defines.svh"

    localparam int CW = cuv_pkg::CW;
    localparam int AW = cuv_pkg::AW;
    localparam int TW = cuv_pkg::TW;
    localparam int NS = cuv_pkg::CORDIC_STEPS;

    logic [63:0]        row_x_reg, row_y_reg, row_z_reg;
    logic signed [15:0] tile_u_reg, tile_v_reg;
    logic               wrap_reg;
    logic [cuv_pkg::DEPTH-1:0] vld_reg;
    logic [cuv_pkg::DEPTH-1:0] en;
    logic               accept;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= 64'h1000;
            row_y_reg  <= 64'h1000_0000;
            row_z_reg  <= 64'h1000_0000_0000;
            tile_u_reg <= 16'sd256;
            tile_v_reg <= 16'sd256;
            wrap_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cuv_pkg::REG_ROW_X:  row_x_reg  <= cfg_data;
                cuv_pkg::REG_ROW_Y:  row_y_reg  <= cfg_data;
                cuv_pkg::REG_ROW_Z:  row_z_reg  <= cfg_data;
                cuv_pkg::REG_TILE_U: tile_u_reg <= cfg_data[15:0];
                cuv_pkg::REG_TILE_V: tile_v_reg <= cfg_data[15:0];
                cuv_pkg::REG_WRAP:   wrap_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage enables: a slot moves when the slot ahead moves or is empty
    always_comb
    begin
        en[cuv_pkg::DEPTH-1] = !vld_reg[cuv_pkg::DEPTH-1] || out_ready;
        for (int i = cuv_pkg::DEPTH - 2; i >= 0; i--)
        begin
            en[i] = en[i+1] || !vld_reg[i];
        end
    end

    assign in_ready = en[0];
    assign accept   = in_valid && in_ready;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < cuv_pkg::DEPTH; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: nine products
    logic signed [31:0] p_reg [9];
    logic signed [15:0] c_w [9];
    logic signed [15:0] pos_w [3];
    logic signed [15:0] tr_x_reg, tr_y_reg, tr_z_reg;

    always_comb
    begin
        pos_w[0] = pos_x;
        pos_w[1] = pos_y;
        pos_w[2] = pos_z;
        for (int k = 0; k < 3; k++)
        begin
            c_w[k]     = row_x_reg[16*k +: 16];
            c_w[3 + k] = row_y_reg[16*k +: 16];
            c_w[6 + k] = row_z_reg[16*k +: 16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 9; r++)
            begin
                p_reg[r] <= c_w[r] * pos_w[r % 3];
            end
            tr_x_reg <= row_x_reg[63:48];
            tr_y_reg <= row_y_reg[63:48];
            tr_z_reg <= row_z_reg[63:48];
        end
    end

    // Stage 2: row sums
    logic signed [TW-1:0] tx_reg, ty_reg, tz_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tx_reg <= TW'(p_reg[0]) + TW'(p_reg[1]) + TW'(p_reg[2])
                + (TW'(tr_x_reg) <<< 12);
            ty_reg <= TW'(p_reg[3]) + TW'(p_reg[4]) + TW'(p_reg[5])
                + (TW'(tr_y_reg) <<< 12);
            tz_reg <= TW'(p_reg[6]) + TW'(p_reg[7]) + TW'(p_reg[8])
                + (TW'(tr_z_reg) <<< 12);
        end
    end

    // Stage 3: v product, and bit length of the larger magnitude
    localparam int LW = 6;
    logic [TW-1:0]        mx, mz, mm;
    logic [LW-1:0]        nbits;
    logic [LW-1:0]        n_reg;
    logic signed [TW-1:0] ax_reg, az_reg;
    logic signed [47:0]   vprod_reg;

    always_comb
    begin
        mx = tx_reg[TW-1] ? TW'(-tx_reg) : TW'(tx_reg);
        mz = tz_reg[TW-1] ? TW'(-tz_reg) : TW'(tz_reg);
        mm = (mx > mz) ? mx : mz;
        nbits = '0;
        for (int b = 0; b < TW; b++)
        begin
            if (mm[b])
            begin
                nbits = LW'(b + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            n_reg     <= nbits;
            ax_reg    <= tx_reg;
            az_reg    <= tz_reg;
            vprod_reg <= 48'(ty_reg) * 48'(tile_v_reg);
        end
    end

    // Stage 4: normalize, pre-rotate into the right half plane, finish v
    cuv_pkg::cell_word_t seed_next;
    cuv_pkg::cell_word_t seed_reg;
    logic signed [TW+CW-1:0] sx, sz;
    logic signed [CW-1:0]    nx_w, nz_w;
    logic signed [47:0]      vr;
    logic signed [47:0]      vd;

    always_comb
    begin
        sx = (TW+CW)'(ax_reg);
        sz = (TW+CW)'(az_reg);
        if (n_reg > LW'(cuv_pkg::COORD_BITS - 1))
        begin
            nx_w = CW'(sx >>> (n_reg - LW'(cuv_pkg::COORD_BITS - 1)));
            nz_w = CW'(sz >>> (n_reg - LW'(cuv_pkg::COORD_BITS - 1)));
        end
        else
        begin
            nx_w = CW'(sx <<< (LW'(cuv_pkg::COORD_BITS - 1) - n_reg));
            nz_w = CW'(sz <<< (LW'(cuv_pkg::COORD_BITS - 1) - n_reg));
        end
        seed_next.acc = '0;
        seed_next.cx  = nz_w;
        seed_next.cy  = nx_w;
        if (n_reg == '0)
        begin
            seed_next.cx = '0;
            seed_next.cy = '0;
        end
        else if (nz_w[CW-1])
        begin
            if (!nx_w[CW-1])
            begin
                seed_next.cx  = nx_w;
                seed_next.cy  = -nz_w;
                seed_next.acc = cuv_pkg::QUARTER_TURN;
            end
            else
            begin
                seed_next.cx  = -nx_w;
                seed_next.cy  = nz_w;
                seed_next.acc = -cuv_pkg::QUARTER_TURN;
            end
        end
        // Round v, take it from one, then clamp it to the signed 32-bit range
        vr = (vprod_reg + 48'sd4096) >>> 13;
        vd = 48'sd32768 - vr;
        if (vd > 48'sd2147483647)
        begin
            seed_next.v = 32'sh7fffffff;
        end
        else if (vd < -48'sd2147483648)
        begin
            seed_next.v = 32'sh80000000;
        end
        else
        begin
            seed_next.v = 32'(vd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            seed_reg <= seed_next;
        end
    end

    // CORDIC chain; a zero vector stays at zero, and its flag forces theta to 0
    cuv_pkg::cell_word_t chain [NS+1];
    logic                zero_reg [NS+1];
    assign chain[0] = seed_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            zero_reg[0] <= (n_reg == '0);
        end
        for (int i = 0; i < NS; i++)
        begin
            if (en[cuv_pkg::PRE_STAGES + i])
            begin
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        cuv_cordic_cell u_cell (
            .clk   (clk),
            .en    (en[cuv_pkg::PRE_STAGES + g]),
            .shift (5'(g)),
            .angle (cuv_pkg::atan_turn(g)),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // Post 1: u product
    localparam int PS = cuv_pkg::PRE_STAGES + NS;
    logic signed [AW-1:0] theta, a_w;
    logic signed [51:0]   uprod_reg;
    logic signed [31:0]   v1_reg;

    assign theta = zero_reg[NS] ? '0 : chain[NS].acc;
    assign a_w   = cuv_pkg::QUARTER_TURN - theta;

    always_ff @(posedge clk)
    begin
        if (en[PS])
        begin
            uprod_reg <= 52'(a_w) * 52'(tile_u_reg);
            v1_reg    <= chain[NS].v;
        end
    end

    // Post 2: round, wrap
    logic signed [51:0] ur;
    logic signed [51:0] uw;
    logic signed [51:0] u2_reg;
    logic signed [31:0] v2_reg;

    always_comb
    begin
        ur = (uprod_reg + 52'sd8388608) >>> 24;
        uw = ur;
        if (wrap_reg)
        begin
            if (!ur[51])
            begin
                uw = {36'd0, ur[15:0]};
            end
            else
            begin
                uw = -{36'd0, 16'((-ur))};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[PS+1])
        begin
            u2_reg <= uw;
            v2_reg <= v1_reg;
        end
    end

    // Post 3: saturate into the output register
    logic signed [31:0] u_sat;
    always_comb
    begin
        if (u2_reg > 52'sd2147483647)
        begin
            u_sat = 32'sh7fffffff;
        end
        else if (u2_reg < -52'sd2147483648)
        begin
            u_sat = 32'sh80000000;
        end
        else
        begin
            u_sat = 32'(u2_reg);
        end
    end

    logic signed [31:0] u_out_reg, v_out_reg;
    always_ff @(posedge clk)
    begin
        if (en[PS+2])
        begin
            u_out_reg <= u_sat;
            v_out_reg <= v2_reg;
        end
    end

    assign out_valid = vld_reg[cuv_pkg::DEPTH-1];
    assign tex_u     = u_out_reg;
    assign tex_v     = v_out_reg;

    `CUV_ASSERT_NEXT(a_hold_stall, clk, rst_n, out_valid && !out_ready, out_valid)
    `CUV_ASSERT_IMP(a_full_blocks, clk, rst_n, (&vld_reg) && !out_ready, !in_ready)
    `CUV_ASSERT_NEXT(a_take_empty, clk, rst_n, accept, vld_reg[0])
endmodule
